// ===== hdl/utd_pkg.sv =====
// ----------------------------------------------------------------------------
// utd_pkg: shared definitions for the timestamp to calendar date converter
// Holds the calendar constants, the sequencer states, the command to the
// serial divider and the small lookup and padding functions.
// ----------------------------------------------------------------------------
package utd_pkg;

    localparam int TIMESTAMP_BITS_DEFAULT = 36;

    // Remainder and divisor width of the serial divider: the largest divisor
    // is the day count of 400 years, which needs 18 bits.
    localparam int DIV_W  = 18;
    localparam int STEP_W = 6;
    localparam int YEAR_W = 13;
    localparam int M_TDATA_W = 40;

    localparam logic [DIV_W-1:0] SECS_PER_DAY  = 18'd86400;
    localparam logic [DIV_W-1:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [DIV_W-1:0] SECS_PER_MIN  = 18'd60;
    localparam logic [DIV_W-1:0] DAYS_400Y     = 18'd146097;
    localparam logic [DIV_W-1:0] DAYS_4Y       = 18'd1461;
    localparam logic [DIV_W-1:0] PADDED_YEAR   = 18'd366;
    localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 13'd1970;

    // Skipped century leap days inside a 400-year cycle counted from 1970.
    localparam logic [17:0] CENT_SKIP_1 = 18'd47541;
    localparam logic [17:0] CENT_SKIP_2 = 18'd84066;
    localparam logic [17:0] CENT_SKIP_3 = 18'd120591;

    // Missing February 29 of the three common years of a 4-year cycle.
    localparam logic [10:0] FEB_SKIP_1 = 11'd59;
    localparam logic [10:0] FEB_SKIP_2 = 11'd425;
    localparam logic [10:0] FEB_SKIP_3 = 11'd1157;

    localparam logic [3:0] LAST_MONTH = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAYS,
        ST_HOUR,
        ST_MIN,
        ST_C400,
        ST_P400,
        ST_C4,
        ST_P4,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } utd_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } utd_div_cmd_t;

    // Padded-year month lengths: February always has 29 slots.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:                       len = 5'd29;
            4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [17:0] pad_century(input logic [17:0] d);
        logic [17:0] p;
        p = d;
        if (p >= CENT_SKIP_1) p = p + 18'd1;
        if (p >= CENT_SKIP_2) p = p + 18'd1;
        if (p >= CENT_SKIP_3) p = p + 18'd1;
        return p;
    endfunction

    function automatic logic [10:0] pad_feb(input logic [10:0] d);
        logic [10:0] p;
        p = d;
        if (p >= FEB_SKIP_1) p = p + 11'd1;
        if (p >= FEB_SKIP_2) p = p + 11'd1;
        if (p >= FEB_SKIP_3) p = p + 11'd1;
        return p;
    endfunction

endpackage

// ===== hdl/unix_time_to_utc_date.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_utc_date: Unix timestamp to UTC calendar date and time
//
//   channel  direction  tdata fields (low bit first)
//   s_       in         seconds_since_epoch
//   m_       out        second, minute, hour, day, month, year
//
// One timestamp is converted at a time. A shared bit-serial divider runs six
// divisions in turn (by 86400, 3600, 60, 146097, 1461 and 366), one quotient
// bit per cycle; a month walk then finds the month and the day of month. The
// result is loaded into the output register and the converter goes back to
// idle, where it takes the next timestamp. Reset is synchronous and clears the
// sequencer and the output valid. A finished result waits in the output
// register while the next timestamp is accepted and converted; if it is still
// waiting when the next conversion ends, the converter holds and refuses input
// until it is taken.
// ----------------------------------------------------------------------------
module unix_time_to_utc_date #(
    parameter int TIMESTAMP_BITS = utd_pkg::TIMESTAMP_BITS_DEFAULT,
    localparam int S_TDATA_W = ((TIMESTAMP_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [S_TDATA_W-1:0]          s_tdata,   // seconds_since_epoch
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
    // month_of_year, year_number
    output logic [utd_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DAYS_W = TIMESTAMP_BITS - 16;
    localparam int P4     = (DAYS_W > 17) ? 17 : DAYS_W - 1;
    localparam int N4     = DAYS_W - P4;
    localparam int DW     = utd_pkg::DIV_W;

    utd_pkg::utd_state_t   state_reg, state_next;
    utd_pkg::utd_div_cmd_t div_cmd;
    logic [DW-1:0]             div_rem_init;
    logic [TIMESTAMP_BITS-1:0] div_sr_init;
    logic                      div_done;
    logic [DW-1:0]             div_rem;
    logic [TIMESTAMP_BITS-1:0] div_sr;
    logic [TIMESTAMP_BITS-1:0] ts;

    logic [DAYS_W-1:0] days_reg;
    logic [4:0]        hour_reg;
    logic [5:0]        min_reg;
    logic [5:0]        sec_reg;
    logic [N4-1:0]     c400_reg;
    logic [6:0]        c4_reg;
    logic [17:0]       pad_reg;
    logic [utd_pkg::YEAR_W-1:0] year_reg, year_next;

    logic       mon_start;
    logic       mon_done;
    logic [4:0] mon_day;
    logic [3:0] mon_month;

    logic                          out_load;
    logic                          m_tvalid_reg;
    logic [utd_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign ts = s_tdata[TIMESTAMP_BITS-1:0];

    // Year from the cycle counts; 400 * c400 is built from three shifts.
    assign year_next = utd_pkg::EPOCH_YEAR
                     + utd_pkg::YEAR_W'(div_sr[1:0])
                     + (utd_pkg::YEAR_W'(c4_reg) << 2)
                     + (utd_pkg::YEAR_W'(c400_reg) << 8)
                     + (utd_pkg::YEAR_W'(c400_reg) << 7)
                     + (utd_pkg::YEAR_W'(c400_reg) << 4);

    always_comb begin
        state_next     = state_reg;
        div_cmd        = '0;
        div_rem_init   = '0;
        div_sr_init    = '0;
        mon_start      = 1'b0;
        out_load       = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            utd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    div_cmd.start   = 1'b1;
                    div_cmd.divisor = utd_pkg::SECS_PER_DAY;
                    div_cmd.steps   = utd_pkg::STEP_W'(DAYS_W);
                    div_rem_init    = DW'(ts[TIMESTAMP_BITS-1 -: 16]);
                    div_sr_init     = {ts[TIMESTAMP_BITS-17:0], 16'b0};
                    state_next      = utd_pkg::ST_DAYS;
                end
            end
            utd_pkg::ST_DAYS: begin
                if (div_done) begin
                    // Second of day is below 2^17: eleven bits preload.
                    div_cmd.start   = 1'b1;
                    div_cmd.divisor = utd_pkg::SECS_PER_HOUR;
                    div_cmd.steps   = utd_pkg::STEP_W'(6);
                    div_rem_init    = DW'(div_rem[16:6]);
                    div_sr_init     = {div_rem[5:0], {(TIMESTAMP_BITS-6){1'b0}}};
                    state_next      = utd_pkg::ST_HOUR;
                end
            end
            utd_pkg::ST_HOUR: begin
                if (div_done) begin
                    div_cmd.start   = 1'b1;
                    div_cmd.divisor = utd_pkg::SECS_PER_MIN;
                    div_cmd.steps   = utd_pkg::STEP_W'(7);
                    div_rem_init    = DW'(div_rem[11:7]);
                    div_sr_init     = {div_rem[6:0], {(TIMESTAMP_BITS-7){1'b0}}};
                    state_next      = utd_pkg::ST_MIN;
                end
            end
            utd_pkg::ST_MIN: begin
                if (div_done) begin
                    div_cmd.start   = 1'b1;
                    div_cmd.divisor = utd_pkg::DAYS_400Y;
                    div_cmd.steps   = utd_pkg::STEP_W'(N4);
                    div_rem_init    = DW'(days_reg[DAYS_W-1 -: P4]);
                    div_sr_init     = {days_reg[N4-1:0], {(TIMESTAMP_BITS-N4){1'b0}}};
                    state_next      = utd_pkg::ST_C400;
                end
            end
            utd_pkg::ST_C400: begin
                if (div_done) begin
                    state_next = utd_pkg::ST_P400;
                end
            end
            utd_pkg::ST_P400: begin
                div_cmd.start   = 1'b1;
                div_cmd.divisor = utd_pkg::DAYS_4Y;
                div_cmd.steps   = utd_pkg::STEP_W'(8);
                div_rem_init    = DW'(pad_reg[17:8]);
                div_sr_init     = {pad_reg[7:0], {(TIMESTAMP_BITS-8){1'b0}}};
                state_next      = utd_pkg::ST_C4;
            end
            utd_pkg::ST_C4: begin
                if (div_done) begin
                    state_next = utd_pkg::ST_P4;
                end
            end
            utd_pkg::ST_P4: begin
                div_cmd.start   = 1'b1;
                div_cmd.divisor = utd_pkg::PADDED_YEAR;
                div_cmd.steps   = utd_pkg::STEP_W'(3);
                div_rem_init    = DW'(pad_reg[10:3]);
                div_sr_init     = {pad_reg[2:0], {(TIMESTAMP_BITS-3){1'b0}}};
                state_next      = utd_pkg::ST_YEAR;
            end
            utd_pkg::ST_YEAR: begin
                if (div_done) begin
                    mon_start  = 1'b1;
                    state_next = utd_pkg::ST_MONTH;
                end
            end
            utd_pkg::ST_MONTH: begin
                if (mon_done) begin
                    state_next = utd_pkg::ST_DONE;
                end
            end
            utd_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = utd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = utd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= utd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            case (state_reg)
                utd_pkg::ST_DAYS: days_reg <= div_sr[DAYS_W-1:0];
                utd_pkg::ST_HOUR: hour_reg <= div_sr[4:0];
                utd_pkg::ST_MIN: begin
                    min_reg <= div_sr[5:0];
                    sec_reg <= div_rem[5:0];
                end
                utd_pkg::ST_C400: begin
                    c400_reg <= div_sr[N4-1:0];
                    pad_reg  <= utd_pkg::pad_century(div_rem);
                end
                utd_pkg::ST_C4: begin
                    c4_reg  <= div_sr[6:0];
                    pad_reg <= {7'b0, utd_pkg::pad_feb(div_rem[10:0])};
                end
                utd_pkg::ST_YEAR: year_reg <= year_next;
                default: ;
            endcase
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, year_reg, mon_month, mon_day, hour_reg, min_reg, sec_reg};
        end
    end

    utd_div #(
        .SR_W (TIMESTAMP_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (div_cmd),
        .rem_init (div_rem_init),
        .sr_init  (div_sr_init),
        .done     (div_done),
        .rem      (div_rem),
        .sr       (div_sr)
    );

    utd_month u_month (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (mon_start),
        .doy           (div_rem[8:0]),
        .done          (mon_done),
        .day_of_month  (mon_day),
        .month_of_year (mon_month)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hdl/utd_div.sv =====
// ----------------------------------------------------------------------------
// utd_div: bit-serial restoring divider
// Shifts the dividend through a shift register one bit per cycle and builds
// the quotient in the freed low bits. The caller preloads the remainder with
// the top dividend bits that are known to be below the divisor.
// ----------------------------------------------------------------------------
module utd_div #(
    parameter int SR_W = utd_pkg::TIMESTAMP_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  utd_pkg::utd_div_cmd_t     cmd,
    input  logic [utd_pkg::DIV_W-1:0] rem_init,
    input  logic [SR_W-1:0]           sr_init,
    output logic                      done,
    output logic [utd_pkg::DIV_W-1:0] rem,
    output logic [SR_W-1:0]           sr
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [utd_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [utd_pkg::DIV_W-1:0]   dvs_reg, dvs_next;
    logic [utd_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [SR_W-1:0]             sr_reg, sr_next;
    logic [utd_pkg::DIV_W:0]     trial;
    logic [utd_pkg::DIV_W:0]     diff;
    logic                        fits;

    assign trial = {rem_reg, sr_reg[SR_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        sr_next   = sr_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
            dvs_next  = cmd.divisor;
            rem_next  = rem_init;
            sr_next   = sr_init;
        end else if (busy_reg) begin
            rem_next = fits ? diff[utd_pkg::DIV_W-1:0] : trial[utd_pkg::DIV_W-1:0];
            sr_next  = {sr_reg[SR_W-2:0], fits};
            cnt_next = cnt_reg - utd_pkg::STEP_W'(1);
            if (cnt_reg == utd_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        sr_reg  <= sr_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign sr   = sr_reg;

endmodule

// ===== hdl/utd_month.sv =====
// ----------------------------------------------------------------------------
// utd_month: month walk over a padded 366-slot year
// Subtracts one month length per cycle until the remaining day index falls
// inside the current month, then reports day of month and month, both from 1.
// ----------------------------------------------------------------------------
module utd_month (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  logic [8:0] doy,
    output logic       done,
    output logic [4:0] day_of_month,
    output logic [3:0] month_of_year
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [8:0] doy_reg, doy_next;
    logic [3:0] mon_reg, mon_next;
    logic [4:0] len;

    assign len = utd_pkg::month_len(mon_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        doy_next  = doy_reg;
        mon_next  = mon_reg;
        if (start) begin
            busy_next = 1'b1;
            doy_next  = doy;
            mon_next  = '0;
        end else if (busy_reg) begin
            if (mon_reg < utd_pkg::LAST_MONTH && doy_reg >= {4'b0, len}) begin
                doy_next = doy_reg - {4'b0, len};
                mon_next = mon_reg + 4'd1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        doy_reg <= doy_next;
        mon_reg <= mon_next;
    end

    assign done          = done_reg;
    assign day_of_month  = doy_reg[4:0] + 5'd1;
    assign month_of_year = mon_reg + 4'd1;

endmodule

// ===== hdl/utd_check.sv =====
// ----------------------------------------------------------------------------
// utd_check: port-level checks for the timestamp converter
// Watches the stream handshakes and the ranges of the time fields in each
// result transaction.
// ----------------------------------------------------------------------------
module utd_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [utd_pkg::M_TDATA_W-1:0] m_tdata
);

    // A result stays offered until it is taken.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    // A stalled result keeps its data.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // The converter works on one timestamp at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input transaction taken during a conversion");

    // Every delivered time of day, day and month lies in its calendar range.
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60)
                  && (m_tdata[16:12] < 5'd24) && (m_tdata[21:17] != 5'd0)
                  && (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] <= 4'd12))
        else $error("result field out of calendar range");

endmodule

bind unix_time_to_utc_date utd_check u_utd_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/unix_time_to_utc_date_test.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_utc_date_test: self-checking bench for the timestamp converter
// Drives timestamps into the input stream and checks every output
// transaction against a calendar predictor built into the bench. It covers
// directed calendar edges, random stamps under three idling mixes and one
// long output stall that backs the converter up into its input.
// ----------------------------------------------------------------------------
module unix_time_to_utc_date_test;

    localparam int STAMP_W = 36;
    localparam int S_DATA_W = 40;

    localparam longint unsigned SECS_IN_MIN  = 60;
    localparam longint unsigned MINS_IN_HOUR = 60;
    localparam longint unsigned HOURS_IN_DAY = 24;
    localparam longint unsigned SECS_IN_DAY  = 86400;
    localparam longint unsigned DAYS_IN_400Y = 146097;
    localparam int unsigned DAYS_IN_4Y       = 1461;
    localparam int unsigned SLOTS_PER_YEAR   = 366;
    localparam int unsigned FIRST_YEAR       = 1970;
    localparam int unsigned CENTURY_OFS      = 789;
    localparam int unsigned FEB_GAP_1        = 59;
    localparam int unsigned FEB_GAP_2        = 425;
    localparam int unsigned FEB_GAP_3        = 1157;
    localparam int unsigned LAST_MONTH_IDX   = 11;

    localparam int ITEMS_PER_PHASE = 450;
    localparam int STALL_CYCLES    = 600;
    localparam int DRAIN_CYCLES    = 100;

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } civil_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [39:0]         m_tdata;

    civil_t pending_dates[$];
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     hold_cycles = 0;
    int     error_count = 0;
    int     checked_count = 0;
    civil_t got_date;
    civil_t want_date;

    unix_time_to_utc_date #(.TIMESTAMP_BITS(STAMP_W)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // seconds_since_epoch
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
        // month_of_year, year_number
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1600000;
        $display("Timeout: %0d results still outstanding", pending_dates.size());
        $display("Test completed with failures");
        $finish;
    end

    // Calendar predictor: splits the stamp and pads every year to 366 slots.
    function automatic civil_t stamp_to_civil(input logic [STAMP_W-1:0] stamp);
        longint unsigned total;
        longint unsigned mins;
        longint unsigned hours;
        longint unsigned days;
        longint unsigned cycles400;
        int unsigned     in400;
        int unsigned     cycles4;
        int unsigned     in4;
        int unsigned     slot;
        int unsigned     len;
        int unsigned     mon;
        longint unsigned year;
        civil_t          res;
        total = 64'(stamp);
        mins = total / SECS_IN_MIN;
        hours = mins / MINS_IN_HOUR;
        days = hours / HOURS_IN_DAY;
        res.second = 6'(total % SECS_IN_MIN);
        res.minute = 6'(mins % MINS_IN_HOUR);
        res.hour = 5'(hours % HOURS_IN_DAY);
        cycles400 = days / DAYS_IN_400Y;
        in400 = 32'(days % DAYS_IN_400Y);
        if (in400 >= 32 * DAYS_IN_4Y + CENTURY_OFS) in400++;
        if (in400 >= 57 * DAYS_IN_4Y + CENTURY_OFS) in400++;
        if (in400 >= 82 * DAYS_IN_4Y + CENTURY_OFS) in400++;
        cycles4 = in400 / DAYS_IN_4Y;
        in4 = in400 % DAYS_IN_4Y;
        if (in4 >= FEB_GAP_1) in4++;
        if (in4 >= FEB_GAP_2) in4++;
        if (in4 >= FEB_GAP_3) in4++;
        slot = in4 % SLOTS_PER_YEAR;
        year = 64'(in4 / SLOTS_PER_YEAR) + 64'(cycles4) * 4 + cycles400 * 400
             + 64'(FIRST_YEAR);
        mon = 0;
        len = 31;
        while (mon < LAST_MONTH_IDX && slot >= len) begin
            slot -= len;
            mon++;
            if (mon == 1) len = 29;
            else if (mon == 3 || mon == 5 || mon == 8 || mon == 10) len = 30;
            else len = 31;
        end
        res.day = 5'(slot + 1);
        res.month = 4'(mon + 1);
        res.year = 13'(year);
        return res;
    endfunction

    // Seconds since the epoch of a Gregorian date and time, for aiming stimulus.
    function automatic longint utc_stamp(input int y, input int mo, input int d,
                                         input int h, input int mi, input int s);
        int yy;
        int era;
        int yoe;
        int mp;
        int doy;
        int doe;
        yy = (mo <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return (longint'(era) * 146097 + longint'(doe) - 719468) * 86400
               + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s);
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    // Offers one timestamp and waits until the converter takes the transaction.
    task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_DATA_W - STAMP_W){1'b0}}, stamp};
        do @(posedge aclk); while (!s_tready);
        pending_dates.push_back(stamp_to_civil(stamp));
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    // Receiver: random backpressure, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_date = m_tdata[38:0];
            if (pending_dates.size() == 0) begin
                report_error($sformatf("unexpected result %h", m_tdata));
            end else begin
                want_date = pending_dates.pop_front();
                check_field("second", int'(got_date.second), int'(want_date.second));
                check_field("minute", int'(got_date.minute), int'(want_date.minute));
                check_field("hour", int'(got_date.hour), int'(want_date.hour));
                check_field("day", int'(got_date.day), int'(want_date.day));
                check_field("month", int'(got_date.month), int'(want_date.month));
                check_field("year", int'(got_date.year), int'(want_date.year));
                checked_count++;
            end
        end
    end

    task automatic test_calendar_edges();
        send_stamp('0);
        send_stamp('1);
        send_stamp(36'hFFFF_FFFF);
        send_stamp(36'h8_0000_0000);
        send_stamp(36'h7_FFFF_FFFF);
        send_stamp(STAMP_W'(utc_stamp(1970, 12, 31, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(1972, 2, 29, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(1972, 3, 1, 0, 0, 0)));
        send_stamp(STAMP_W'(utc_stamp(1973, 2, 28, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(1973, 3, 1, 0, 0, 0)));
        send_stamp(STAMP_W'(utc_stamp(1973, 12, 31, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2000, 2, 29, 12, 34, 56)));
        send_stamp(STAMP_W'(utc_stamp(2000, 12, 31, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2100, 2, 28, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2100, 3, 1, 0, 0, 0)));
        send_stamp(STAMP_W'(utc_stamp(2200, 3, 1, 0, 0, 0)));
        send_stamp(STAMP_W'(utc_stamp(2300, 2, 28, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2369, 12, 31, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2370, 1, 1, 0, 0, 0)));
        send_stamp(STAMP_W'(utc_stamp(2400, 2, 29, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2400, 12, 31, 23, 59, 59)));
        send_stamp(STAMP_W'(utc_stamp(2038, 1, 19, 3, 14, 8)));
        send_stamp(STAMP_W'(utc_stamp(4147, 8, 20, 7, 32, 15)));
    endtask

    task automatic test_random_stamps(input int count);
        int     kind;
        int     yr;
        longint stamp;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(0, 9);
            yr = $urandom_range(1971, 4146);
            case (kind)
                0, 1, 2, 3: stamp = {$urandom_range(0, 15), $urandom};
                4, 5, 6: stamp = utc_stamp(yr, $urandom_range(1, 12), 1,
                                           $urandom_range(0, 23), $urandom_range(0, 59),
                                           $urandom_range(0, 59))
                                 + longint'($urandom_range(0, 30)) * SECS_IN_DAY;
                // Around the end of February, leap and common years alike.
                7: stamp = utc_stamp(yr, 3, 1, 0, 0, 0)
                           + longint'($urandom_range(0, 345600)) - 172800;
                // Around the end of February of a century year, leap or not.
                8: stamp = utc_stamp(100 * $urandom_range(21, 41), 3, 1, 0, 0, 0)
                           + longint'($urandom_range(0, 345600)) - 172800;
                default: stamp = longint'($urandom);
            endcase
            send_stamp(stamp[STAMP_W-1:0]);
        end
    endtask

    // Holds the output off long enough that the converter must refuse input.
    task automatic test_output_stall();
        int saved_tx;
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        hold_cycles <= STALL_CYCLES;
        @(posedge aclk);
        for (int i = 0; i < 8; i++)
            send_stamp(STAMP_W'({$urandom_range(0, 15), $urandom}));
        tx_idle_pct = saved_tx;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(19, 72);
        test_calendar_edges();
        test_random_stamps(ITEMS_PER_PHASE);
        test_output_stall();
        set_idling(72, 19);
        test_random_stamps(ITEMS_PER_PHASE);
        set_idling(0, 0);
        test_random_stamps(ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d conversions: calendar edges, random stamps up to 36 bits,",
                 checked_count);
        $display("three idling mixes and a %0d-cycle output stall.", STALL_CYCLES);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/utd_pkg.sv
hdl/utd_div.sv
hdl/utd_month.sv
hdl/unix_time_to_utc_date.sv
hdl/utd_check.sv
test/unix_time_to_utc_date_test.sv
